// ===== rtl/adjacency_matrix_graph_traversal_top_defines.svh =====
// assertion macros for the adjacency matrix graph traversal block
`ifndef ADJACENCY_MATRIX_GRAPH_TRAVERSAL_TOP_DEFINES_SVH
`define ADJACENCY_MATRIX_GRAPH_TRAVERSAL_TOP_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define AMGT_ASSERT_NOW(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define AMGT_ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/amgt_pkg.sv =====
// shared types and constants for the graph traversal block
`timescale 1ns / 1ps

package amgt_pkg;

    localparam int VTX_W       = 5;
    localparam int MODE_W      = 2;
    localparam int CFG_W       = 6;
    localparam int MAX_RESULTS = 32;

    localparam logic [CFG_W-1:0] COUNT_RESET = 6'd32;

    // item operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_EDGE = 2'd0,
        MODE_DFS  = 2'd1,
        MODE_BFS  = 2'd2
    } mode_t;

    // source of the adjacency row address
    typedef enum logic [2:0] {
        SRC_A,
        SRC_B,
        SRC_TOP,
        SRC_FOUND,
        SRC_WORK
    } adj_src_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic     load_in;
        logic     adj_rd;
        logic     adj_wr;
        adj_src_t adj_src;
        logic     start;
        logic     push;
        logic     pop;
        logic     fetch;
        logic     load_top;
        logic     finish;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        mode_t mode;
        logic  edge_ok;
        logic  cand_any;
        logic  out_free;
        logic  tail_is_one;
        logic  fifo_empty;
    } dp_sts_t;

endpackage

// ===== rtl/adjacency_matrix_graph_traversal_top.sv =====
// Adjacency matrix graph traversal: edge adds, depth-first and breadth-first walks.
// Edge item: read-modify-write of two rows (row a, then row b), no beat.
// DFS and BFS read their adjacency rows from the single-port adjacency memory with
// registered read.
// One item at a time; output beats wait on out_stall, the final beat carries is_last.
// Reset (rst_n low, asynchronous): no edges, vertex count 32, controller idle.
`timescale 1ns / 1ps
`include "adjacency_matrix_graph_traversal_top_defines.svh"

module adjacency_matrix_graph_traversal_top #(
    parameter int VERTICES = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [amgt_pkg::MODE_W-1:0] mode,
    input  logic [amgt_pkg::VTX_W-1:0]  vertex_a,
    input  logic [amgt_pkg::VTX_W-1:0]  vertex_b,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [amgt_pkg::CFG_W-1:0]  vertex_count,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [amgt_pkg::VTX_W-1:0]  visited_vertex,
    output logic                       is_last
);

    import amgt_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    cfg_we;

    // register write taken at any time
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    amgt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    amgt_datapath #(
        .VERTICES (VERTICES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode           (mode),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .cfg_we         (cfg_we),
        .vertex_count   (vertex_count),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .visited_vertex (visited_vertex),
        .is_last        (is_last)
    );

    // checks
    `AMGT_ASSERT_NOW(a_beat_room, cmd.push || cmd.finish, sts.out_free, "output register full")
    `AMGT_ASSERT_NEXT(a_idle_after_last, cmd.finish, !in_stall, "not idle after final beat")
    `AMGT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "stall missing")

endmodule

// ===== rtl/amgt_datapath.sv =====
// datapath: adjacency memory, visited marks, work list, counters and output register
`timescale 1ns / 1ps

module amgt_datapath #(
    parameter int VERTICES = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [amgt_pkg::MODE_W-1:0] mode,
    input  logic [amgt_pkg::VTX_W-1:0]  vertex_a,
    input  logic [amgt_pkg::VTX_W-1:0]  vertex_b,
    input  logic                       cfg_we,
    input  logic [amgt_pkg::CFG_W-1:0]  vertex_count,
    input  logic                       out_stall,
    input  amgt_pkg::dp_cmd_t          cmd,
    output amgt_pkg::dp_sts_t          sts,
    output logic                       out_valid,
    output logic [amgt_pkg::VTX_W-1:0]  visited_vertex,
    output logic                       is_last
);

    import amgt_pkg::*;

    localparam int ROW_W = $clog2(VERTICES);
    localparam int CNT_W = $clog2(VERTICES + 1);

    // bit i set for every neighbour index the walks may follow
    function automatic logic [VERTICES-1:0] limit_mask(input logic [CFG_W-1:0] cnt);
        logic [VERTICES-1:0] m;
        for (int i = 0; i < VERTICES; i++) begin
            m[i] = (i < int'(cnt)) && (i < MAX_RESULTS);
        end
        return m;
    endfunction

    function automatic logic [VERTICES-1:0] vertex_onehot(input logic [VTX_W-1:0] v);
        logic [VERTICES-1:0] m;
        for (int i = 0; i < VERTICES; i++) begin
            m[i] = (i == int'(v));
        end
        return m;
    endfunction

    // latched item
    logic [MODE_W-1:0] mode_reg;
    logic [VTX_W-1:0]  vertex_a_reg;
    logic [VTX_W-1:0]  vertex_b_reg;

    logic [VERTICES-1:0] lim_mask_reg;
    logic [VERTICES-1:0] visited_reg;

    // adjacency rows and per-row valid bits
    logic [VERTICES-1:0] adj_mem [VERTICES];
    logic [VERTICES-1:0] row_valid_reg;
    logic [VERTICES-1:0] adj_rdata_reg;
    logic                adj_rvalid_reg;
    logic [VERTICES-1:0] adj_row;
    logic [VERTICES-1:0] edge_bit;
    logic [VTX_W-1:0]    adj_vtx;
    logic [ROW_W-1:0]    adj_addr;

    // stack or fifo of vertex indexes
    logic [VTX_W-1:0] work_mem [VERTICES];
    logic [VTX_W-1:0] work_rdata_reg;
    logic             work_we;
    logic             work_re;
    logic [ROW_W-1:0] work_waddr;
    logic [ROW_W-1:0] work_raddr;
    logic [VTX_W-1:0] work_wdata;
    logic [CNT_W-1:0] head_reg;
    logic [CNT_W-1:0] tail_reg;
    logic [CNT_W-1:0] tail_m2;

    logic [VTX_W-1:0]    top_reg;
    logic [VTX_W-1:0]    pending_reg;
    logic [VERTICES-1:0] cand;
    logic [VTX_W-1:0]    found;

    logic             out_valid_reg;
    logic [VTX_W-1:0] out_vertex_reg;
    logic             out_last_reg;
    logic             out_free;

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg     <= mode;
            vertex_a_reg <= vertex_a;
            vertex_b_reg <= vertex_b;
        end
    end

    // scan limit from the vertex count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_mask_reg <= limit_mask(COUNT_RESET);
        end
        else if (cfg_we)
        begin
            lim_mask_reg <= limit_mask(vertex_count);
        end
    end

    // adjacency row address select
    always_comb
    begin
        case (cmd.adj_src)
            SRC_A:     adj_vtx = vertex_a_reg;
            SRC_B:     adj_vtx = vertex_b_reg;
            SRC_TOP:   adj_vtx = top_reg;
            SRC_FOUND: adj_vtx = found;
            SRC_WORK:  adj_vtx = work_rdata_reg;
            default:   adj_vtx = vertex_a_reg;
        endcase
    end

    assign adj_addr = ROW_W'(adj_vtx);
    assign adj_row  = adj_rvalid_reg ? adj_rdata_reg : '0;
    assign edge_bit = (cmd.adj_src == SRC_B) ? vertex_onehot(vertex_a_reg)
                                             : vertex_onehot(vertex_b_reg);

    // adjacency memory ports
    always_ff @(posedge clk)
    begin
        if (cmd.adj_wr)
        begin
            adj_mem[adj_addr] <= adj_row | edge_bit;
        end
        if (cmd.adj_rd)
        begin
            adj_rdata_reg <= adj_mem[adj_addr];
        end
    end

    // row valid bits, a row never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            adj_rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.adj_wr)
            begin
                row_valid_reg[adj_addr] <= 1'b1;
            end
            if (cmd.adj_rd)
            begin
                adj_rvalid_reg <= row_valid_reg[adj_addr];
            end
        end
    end

    // unvisited neighbours in range and the lowest of them
    assign cand = adj_row & ~visited_reg & lim_mask_reg;

    always_comb
    begin
        found = '0;
        for (int i = VERTICES - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found = VTX_W'(i);
            end
        end
    end

    // work list ports
    assign tail_m2    = tail_reg - CNT_W'(2);
    assign work_we    = cmd.start || cmd.push;
    assign work_waddr = cmd.start ? '0 : tail_reg[ROW_W-1:0];
    assign work_wdata = cmd.start ? '0 : found;
    assign work_re    = cmd.pop || cmd.fetch;
    assign work_raddr = cmd.pop ? tail_m2[ROW_W-1:0] : head_reg[ROW_W-1:0];

    always_ff @(posedge clk)
    begin
        if (work_we)
        begin
            work_mem[work_waddr] <= work_wdata;
        end
        if (work_re)
        begin
            work_rdata_reg <= work_mem[work_raddr];
        end
    end

    // head and tail pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else if (cmd.start)
        begin
            head_reg <= '0;
            tail_reg <= CNT_W'(1);
        end
        else
        begin
            if (cmd.push)
            begin
                tail_reg <= tail_reg + CNT_W'(1);
            end
            else if (cmd.pop)
            begin
                tail_reg <= tail_reg - CNT_W'(1);
            end
            if (cmd.fetch)
            begin
                head_reg <= head_reg + CNT_W'(1);
            end
        end
    end

    // visited marks, cleared after every walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
        end
        else if (cmd.start)
        begin
            visited_reg <= VERTICES'(1);
        end
        else if (cmd.push)
        begin
            visited_reg <= visited_reg | vertex_onehot(found);
        end
        else if (cmd.finish)
        begin
            visited_reg <= '0;
        end
    end

    // stack top and the vertex held back until the next one is known
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            top_reg     <= '0;
            pending_reg <= '0;
        end
        else if (cmd.push)
        begin
            top_reg     <= found;
            pending_reg <= found;
        end
        else if (cmd.load_top)
        begin
            top_reg <= work_rdata_reg;
        end
    end

    // output register
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push || cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.finish)
        begin
            out_vertex_reg <= pending_reg;
            out_last_reg   <= cmd.finish;
        end
    end

    assign out_valid      = out_valid_reg;
    assign visited_vertex = out_vertex_reg;
    assign is_last        = out_last_reg;

    // status to the controller
    always_comb
    begin
        sts.mode        = mode_t'(mode_reg);
        sts.edge_ok     = (int'(vertex_a_reg) < VERTICES) && (int'(vertex_b_reg) < VERTICES);
        sts.cand_any    = |cand;
        sts.out_free    = out_free;
        sts.tail_is_one = (tail_reg == CNT_W'(1));
        sts.fifo_empty  = (head_reg == tail_reg);
    end

endmodule

// ===== rtl/amgt_ctrl.sv =====
// controller: sequences edge writes and depth-first or breadth-first walks
`timescale 1ns / 1ps

module amgt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output amgt_pkg::dp_cmd_t cmd,
    input  amgt_pkg::dp_sts_t sts
);

    import amgt_pkg::*;

    typedef enum logic [3:0] {
        IDLE,
        DISPATCH,
        EDGE_WR_A,
        EDGE_RD_B,
        EDGE_WR_B,
        DFS_READ,
        DFS_SCAN,
        DFS_POP,
        BFS_FETCH,
        BFS_ADJ,
        BFS_SCAN,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = DISPATCH;
                end
            end
            DISPATCH:
            begin
                unique case (sts.mode)
                    MODE_EDGE:
                    begin
                        if (sts.edge_ok)
                        begin
                            cmd.adj_rd  = 1'b1;
                            cmd.adj_src = SRC_A;
                            state_next  = EDGE_WR_A;
                        end
                        else
                        begin
                            state_next = IDLE;
                        end
                    end
                    MODE_DFS:
                    begin
                        cmd.start  = 1'b1;
                        state_next = DFS_READ;
                    end
                    MODE_BFS:
                    begin
                        cmd.start  = 1'b1;
                        state_next = BFS_FETCH;
                    end
                    default:
                    begin
                        state_next = IDLE;
                    end
                endcase
            end
            EDGE_WR_A:
            begin
                cmd.adj_wr  = 1'b1;
                cmd.adj_src = SRC_A;
                state_next  = EDGE_RD_B;
            end
            EDGE_RD_B:
            begin
                cmd.adj_rd  = 1'b1;
                cmd.adj_src = SRC_B;
                state_next  = EDGE_WR_B;
            end
            EDGE_WR_B:
            begin
                cmd.adj_wr  = 1'b1;
                cmd.adj_src = SRC_B;
                state_next  = IDLE;
            end
            DFS_READ:
            begin
                cmd.adj_rd  = 1'b1;
                cmd.adj_src = SRC_TOP;
                state_next  = DFS_SCAN;
            end
            DFS_SCAN:
            begin
                if (sts.cand_any)
                begin
                    // descend into the lowest unvisited neighbour
                    if (sts.out_free)
                    begin
                        cmd.push    = 1'b1;
                        cmd.adj_rd  = 1'b1;
                        cmd.adj_src = SRC_FOUND;
                    end
                end
                else if (sts.tail_is_one)
                begin
                    state_next = FINISH;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = DFS_POP;
                end
            end
            DFS_POP:
            begin
                cmd.load_top = 1'b1;
                cmd.adj_rd   = 1'b1;
                cmd.adj_src  = SRC_WORK;
                state_next   = DFS_SCAN;
            end
            BFS_FETCH:
            begin
                if (sts.fifo_empty)
                begin
                    state_next = FINISH;
                end
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = BFS_ADJ;
                end
            end
            BFS_ADJ:
            begin
                cmd.adj_rd  = 1'b1;
                cmd.adj_src = SRC_WORK;
                state_next  = BFS_SCAN;
            end
            BFS_SCAN:
            begin
                // enqueue neighbours one per cycle in index order while the output register is free
                if (sts.cand_any)
                begin
                    if (sts.out_free)
                    begin
                        cmd.push = 1'b1;
                    end
                end
                else
                begin
                    state_next = BFS_FETCH;
                end
            end
            FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
